>>> rtl/sslip_pkg.sv
package sslip_pkg;

  // Codes carried in the input tuser bit
  typedef enum logic {
    KindLoad   = 1'b0,
    KindSample = 1'b1
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    RegOutputLimit = 2'd0,
    RegEntryCount  = 2'd1
  } cfg_reg_e;

  // Output buffer geometry
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW  = 2;
  localparam int unsigned OutCntW  = 3;

  // One result beat
  typedef struct packed {
    logic [31:0] bits;
    logic        inserted;
    logic        last;
  } sslip_res_t;

  // Results produced by one input beat: none, one or two
  typedef struct packed {
    logic [1:0] num;
    sslip_res_t first;
    sslip_res_t second;
  } sslip_push_t;

endpackage

>>> rtl/sslip_ram.sv
module sslip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read (old data on a same-address write)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sslip_out_fifo.sv
module sslip_out_fifo
  import sslip_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sslip_push_t push_i,
  output logic        room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sslip_res_t  out_res_o
);

  sslip_res_t         mem_q [OutDepth];
  logic [OutPtrW-1:0] wr_q;
  logic [OutPtrW-1:0] rd_q;
  logic [OutCntW-1:0] cnt_q;
  logic               pop;

  assign pop         = (cnt_q != '0) && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rd_q];
  // Room for the worst case of one input beat
  assign room_o      = (cnt_q <= OutCntW'(OutDepth - 2));

  // Result storage, up to two writes per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + OutPtrW'(1)] <= push_i.second;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OutPtrW'(push_i.num);
      rd_q  <= rd_q + OutPtrW'(pop);
      cnt_q <= cnt_q + OutCntW'(push_i.num) - OutCntW'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= OutCntW'(OutDepth))
    else $error("output buffer overfilled");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q - rd_q) == cnt_q[OutPtrW-1:0])
    else $error("output buffer pointers disagree with fill level");

endmodule

>>> rtl/sample_stream_slip_editor.sv
// Sample stream slip editor. Input beats either load the next slip table entry
// (tuser = 0) or present a data sample (tuser = 1). The table entry at the head
// is compared with the running input sample index: a positive entry inserts the
// fill word before that sample, a zero or negative entry drops it; other samples
// pass through unchanged until output_limit words have gone out. The block takes
// one beat per clock while the output keeps up; a sample with an insert gives two
// output beats (just the fill word if that reaches output_limit), the output drains
// one beat per cycle while m_axis_tready is high, and s_axis_tready is low whenever the
// four-entry output buffer has fewer than two free slots. The table sits in a
// RAM with registered read that is always addressed with the next head index,
// so the head entry is ready on the following cycle with no stall; a load to
// the entry being read is forwarded. The table needs no clearing after reset:
// entries are to be loaded before entry_count covers them.
module sample_stream_slip_editor
  import sslip_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // sample_bits[31:0], fill_bits[63:32],
                                     // entry_position[95:64]
  input  logic        s_axis_tuser,  // kind
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // out_bits[31:0]
  output logic        m_axis_tuser,  // inserted
  output logic        m_axis_tlast   // last
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [CW-1:0] load_idx_q, load_idx_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [31:0]   consumed_q, consumed_d;
  logic [30:0]   emitted_q, emitted_d;
  logic [30:0]   limit_q;
  logic [10:0]   entry_count_q;
  logic          fwd_q;
  logic [31:0]   fwd_data_q;

  logic [31:0]   sample_bits, fill_bits, entry_position;
  logic          acc, acc_sample, tbl_we, fwd_d;
  logic [31:0]   ram_rdata, head, head_mag;
  logic          head_valid, head_pos, hit, at_limit, ins_last;
  sslip_push_t   push;
  sslip_res_t    out_res;

  assign sample_bits    = s_axis_tdata[31:0];
  assign fill_bits      = s_axis_tdata[63:32];
  assign entry_position = s_axis_tdata[95:64];

  assign acc        = s_axis_tvalid && s_axis_tready;
  assign acc_sample = acc && (kind_e'(s_axis_tuser) == KindSample);
  assign tbl_we     = acc && (kind_e'(s_axis_tuser) == KindLoad)
                      && (32'(load_idx_q) < 32'(TABLE_DEPTH));

  // Slip table
  sslip_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (load_idx_q[AW-1:0]),
    .wdata_i (entry_position),
    .raddr_i (ptr_d[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Forward a load that hits the entry read in the same cycle
  assign fwd_d = tbl_we && (load_idx_q[AW-1:0] == ptr_d[AW-1:0]);
  assign head  = fwd_q ? fwd_data_q : ram_rdata;

  // Head decode and compare
  assign head_valid = (32'(ptr_q) < 32'(entry_count_q))
                      && (32'(ptr_q) < 32'(TABLE_DEPTH));
  assign head_pos   = !head[31] && (head != '0);
  assign head_mag   = head[31] ? (32'd0 - head) : head;
  assign hit        = head_valid && (head_mag == consumed_q);
  assign at_limit   = (emitted_q >= limit_q);
  assign ins_last   = ((emitted_q + 31'd1) >= limit_q);

  // Edit decision and counter updates
  always_comb begin
    load_idx_d = load_idx_q;
    ptr_d      = ptr_q;
    consumed_d = consumed_q;
    emitted_d  = emitted_q;
    push       = '0;
    if (tbl_we) begin
      load_idx_d = load_idx_q + CW'(1);
    end
    if (acc_sample && !at_limit) begin
      if (hit) begin
        ptr_d = ptr_q + CW'(1);
        if (!head_pos) begin
          consumed_d = consumed_q + 32'd1;
        end else if (ins_last) begin
          emitted_d    = emitted_q + 31'd1;
          push.num     = 2'd1;
          push.first   = '{bits: fill_bits, inserted: 1'b1, last: 1'b1};
        end else begin
          emitted_d    = emitted_q + 31'd2;
          consumed_d   = consumed_q + 32'd1;
          push.num     = 2'd2;
          push.first   = '{bits: fill_bits, inserted: 1'b1, last: 1'b0};
          push.second  = '{bits: sample_bits, inserted: 1'b0, last: 1'b1};
        end
      end else begin
        emitted_d  = emitted_q + 31'd1;
        consumed_d = consumed_q + 32'd1;
        push.num   = 2'd1;
        push.first = '{bits: sample_bits, inserted: 1'b0, last: 1'b1};
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q <= '0;
      ptr_q      <= '0;
      consumed_q <= '0;
      emitted_q  <= '0;
      fwd_q      <= 1'b0;
    end else begin
      load_idx_q <= load_idx_d;
      ptr_q      <= ptr_d;
      consumed_q <= consumed_d;
      emitted_q  <= emitted_d;
      fwd_q      <= fwd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= entry_position;
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q       <= 31'h7FFF_FFFF;
      entry_count_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegOutputLimit: limit_q       <= cfg_data_i;
        RegEntryCount:  entry_count_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Output buffer
  sslip_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = out_res.bits;
  assign m_axis_tuser = out_res.inserted;
  assign m_axis_tlast = out_res.last;

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ptr_q) <= 32'(TABLE_DEPTH))
    else $error("table head ran past the table");

  a_limit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_sample && at_limit) |=> ($stable(emitted_q) && $stable(consumed_q)
                                  && $stable(ptr_q)))
    else $error("state moved on a sample past the output limit");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num != 2'd0) |-> s_axis_tready)
    else $error("results pushed without buffer room");

endmodule

>>> tb/slip_edit_check_pkg.sv
`timescale 1ns / 100ps
package slip_edit_check_pkg;
  import sslip_pkg::*;

  localparam int unsigned SlipDepth = 1024;

  // One expected output beat
  typedef struct {
    logic [31:0] bits;
    logic        inserted;
    logic        last;
  } slip_word_t;

  class slip_edit_scoreboard;
    // Predicted block state
    logic [31:0] positions [SlipDepth];
    int unsigned n_loaded;
    int unsigned head_idx;
    int unsigned in_index;
    int unsigned out_total;
    int unsigned max_out;
    int unsigned n_active;
    int unsigned n_errors;
    slip_word_t  expected_words [$];

    function new();
      n_loaded  = 0;
      head_idx  = 0;
      in_index  = 0;
      out_total = 0;
      max_out   = 32'h7FFF_FFFF;
      n_active  = 0;
      n_errors  = 0;
    endfunction

    function void write_register(cfg_reg_e idx, logic [30:0] val);
      case (idx)
        RegOutputLimit: max_out = {1'b0, val};
        RegEntryCount:  n_active = {21'd0, val[10:0]};
        default: ;
      endcase
    endfunction

    function void push_word(logic [31:0] bits, logic ins, logic last);
      slip_word_t w;
      w.bits     = bits;
      w.inserted = ins;
      w.last     = last;
      expected_words.push_back(w);
    endfunction

    // Apply one accepted input beat and queue the words it produces
    function void predict_edit(kind_e kind, logic [31:0] smp, logic [31:0] fill,
                               logic [31:0] pos);
      logic [31:0] head_pos;
      logic [31:0] mag;
      if (kind == KindLoad) begin
        if (n_loaded < SlipDepth) begin
          positions[n_loaded] = pos;
          n_loaded++;
        end
        return;
      end
      // limit reached: sample ignored, nothing moves
      if (out_total >= max_out) return;
      if (head_idx < n_active && head_idx < SlipDepth) begin
        head_pos = positions[head_idx];
        mag = head_pos[31] ? (32'd0 - head_pos) : head_pos;
        if (mag == in_index) begin
          head_idx++;
          // zero or negative entry drops the sample
          if (head_pos[31] || head_pos == 32'd0) begin
            in_index++;
            return;
          end
          out_total++;
          // insert hit the limit: the fill word closes the beat group
          if (out_total >= max_out) begin
            push_word(fill, 1'b1, 1'b1);
            return;
          end
          push_word(fill, 1'b1, 1'b0);
        end
      end
      push_word(smp, 1'b0, 1'b1);
      out_total++;
      in_index++;
    endfunction

    // Compare one output beat with the oldest expected word
    function void check_word(logic [31:0] bits, logic ins, logic last);
      slip_word_t w;
      if (expected_words.size() == 0) begin
        $error("out_bits: expected no beat, actual %h", bits);
        n_errors++;
        return;
      end
      w = expected_words.pop_front();
      if (bits !== w.bits) begin
        $error("out_bits: expected %h, actual %h", w.bits, bits);
        n_errors++;
      end
      if (ins !== w.inserted) begin
        $error("inserted: expected %b, actual %b", w.inserted, ins);
        n_errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %b, actual %b", w.last, last);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

>>> tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import sslip_pkg::*;
  import slip_edit_check_pkg::*;

  localparam logic [30:0] MaxLimit    = 31'h7FFF_FFFF;
  localparam int unsigned RandomItems = 470;
  localparam int unsigned DrainCycles = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [30:0] cfg_data_i = 31'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = 96'd0;  // sample_bits[31:0], fill_bits[63:32],
                                      // entry_position[95:64]
  logic        s_axis_tuser = 1'b0;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // out_bits[31:0]
  logic        m_axis_tuser;          // inserted
  logic        m_axis_tlast;          // last

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_items = 0;
  int unsigned last_pos = 0;
  slip_edit_scoreboard sb;

  sample_stream_slip_editor i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // Output side: check accepted beats, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic set_idling(input int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
      default: begin send_idle_pct = 25; recv_stall_pct = 25; end
    endcase
  endtask

  // Drive one input beat; called at a rising edge
  task automatic send_beat(input kind_e kind, input logic [31:0] smp,
                           input logic [31:0] fill, input logic [31:0] pos);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {pos, fill, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.predict_edit(kind, smp, fill, pos);
    n_items++;
  endtask

  task automatic send_sample();
    send_beat(KindSample, $urandom, $urandom, $urandom);
  endtask

  task automatic load_entry(input logic [31:0] pos);
    send_beat(KindLoad, $urandom, $urandom, pos);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [30:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_register(idx, val);
  endtask

  // Stop input and let the block run dry
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Next increasing table position that the head has not passed yet
  function automatic logic [31:0] next_position();
    int unsigned floor_pos;
    floor_pos = (last_pos + 1 > sb.in_index) ? last_pos + 1 : sb.in_index;
    last_pos  = floor_pos + $urandom_range(0, 2);
    return $urandom_range(0, 1) ? last_pos : 32'd0 - last_pos;
  endfunction

  // Well-formed edit run: load a few entries, then stream through them
  task automatic edit_burst(input bit ahead, input bit limited);
    int unsigned loads_left;
    loads_left = $urandom_range(1, 8);
    settle();
    if (ahead && !limited) begin
      // count covers the entries before they are loaded; samples wait
      // whenever the head sits on a slot not loaded yet
      write_reg(RegEntryCount, 31'(sb.n_loaded + loads_left));
      while (loads_left > 0 || sb.head_idx < sb.n_active) begin
        if (loads_left > 0 && (sb.head_idx == sb.n_loaded || $urandom_range(0, 1))) begin
          load_entry(next_position());
          loads_left--;
        end else begin
          send_sample();
        end
      end
    end else begin
      repeat (loads_left) load_entry(next_position());
      settle();
      write_reg(RegEntryCount, 31'(sb.n_loaded));
      if (limited) begin
        write_reg(RegOutputLimit, 31'(sb.out_total + $urandom_range(0, 6)));
        repeat (2 * loads_left + 2) send_sample();
        settle();
        write_reg(RegOutputLimit, MaxLimit);
      end
      while (sb.head_idx < sb.n_active) send_sample();
    end
    repeat ($urandom_range(0, 3)) send_sample();
  endtask

  // Plain pass-through samples with no head entry
  task automatic noise_burst();
    settle();
    if ($urandom_range(0, 1)) write_reg(RegEntryCount, 31'($urandom_range(0, sb.head_idx)));
    repeat ($urandom_range(1, 10)) send_sample();
  endtask

  // Output stopped: every sample is ignored
  task automatic stopped_burst();
    settle();
    write_reg(RegOutputLimit, 31'd0);
    if ($urandom_range(0, 1)) write_reg(RegEntryCount, 31'(SlipDepth));
    repeat ($urandom_range(1, 6)) send_sample();
    settle();
    write_reg(RegEntryCount, 31'(sb.head_idx));
    write_reg(RegOutputLimit, MaxLimit);
  endtask

  initial begin
    int unsigned burst_no;
    int unsigned pick;
    sb = new();
    burst_no = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero entry at index 0, insert, drop, back-to-back inserts
    write_reg(RegOutputLimit, MaxLimit);
    send_beat(KindLoad, 32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
    send_beat(KindLoad, 32'h0000_0000, 32'hFFFF_FFFF, 32'd2);
    load_entry(32'hFFFF_FFFD);
    load_entry(32'd4);
    load_entry(32'd5);
    settle();
    write_reg(RegEntryCount, 31'd5);
    send_beat(KindSample, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    send_beat(KindSample, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    send_beat(KindSample, $urandom, 32'hFFFF_FFFF, 32'h0000_0000);
    send_sample();
    send_beat(KindSample, 32'hFFFF_FFFF, 32'h0000_0000, $urandom);
    send_sample();
    send_sample();

    // Count ahead of the loads: entries land while the head reads them
    settle();
    write_reg(RegEntryCount, 31'd7);
    load_entry(32'hFFFF_FFF9);
    load_entry(32'd8);
    send_sample();
    send_sample();

    // Insert that reaches the limit, then ignored samples
    load_entry(32'd9);
    settle();
    write_reg(RegEntryCount, 31'd8);
    write_reg(RegOutputLimit, 31'(sb.out_total + 1));
    send_sample();
    send_sample();
    settle();
    write_reg(RegOutputLimit, 31'(sb.out_total + 1));
    send_sample();
    send_sample();
    settle();
    write_reg(RegOutputLimit, 31'd0);
    write_reg(RegEntryCount, 31'(SlipDepth));
    send_sample();
    settle();
    write_reg(RegEntryCount, 31'(sb.head_idx));
    write_reg(RegOutputLimit, MaxLimit);

    // Random runs, idling pattern changes every few runs
    while (n_items < RandomItems && sb.n_loaded + 8 < SlipDepth) begin
      if (burst_no % 8 == 0) set_idling(burst_no / 8);
      burst_no++;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        edit_burst($urandom_range(0, 1), pick == 6);
      end else if (pick < 9) begin
        noise_burst();
      end else begin
        stopped_burst();
      end
    end

    // Stale head blocks all later edits; fill the table, overflow loads dropped
    set_idling(3);
    settle();
    load_entry(sb.in_index - 1);
    load_entry(32'h7FFF_FFFF);
    load_entry(32'h8000_0001);
    while (sb.n_loaded < SlipDepth) load_entry($urandom);
    repeat (3) load_entry($urandom);
    settle();
    write_reg(RegEntryCount, 31'(SlipDepth));
    repeat (20) send_sample();

    settle();
    if (sb.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
